// File: rtl/core/uvs_pkg.sv
// uvs_pkg: shared types, constants and arithmetic helpers of the UV-sphere mesh generator.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package uvs_pkg;

  localparam int MAX_RINGS_DEF    = 256;
  localparam int MAX_SECTORS_DEF  = 256;
  localparam int ANGLE_STAGES_DEF = 16;

  localparam int CNT_W    = 9;
  localparam int RAD_W    = 16;
  localparam int IDX_W    = 16;
  localparam int COORD_W  = 17;
  localparam int CFG_IW   = 2;
  localparam int DIV_W    = 11;
  localparam int DIV_STEPS = 33;
  localparam int CW       = 34;
  localparam int UW       = 32;

  localparam logic [CFG_IW-1:0] REG_RING_COUNT    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SECTOR_COUNT  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SPHERE_RADIUS = 2'd2;

  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_QUAD   = 1'b1;

  localparam logic signed [CW-1:0] CORDIC_SEED = 34'sd652032874;
  localparam int COORD_LIMIT = 65535;

  typedef struct packed {
    logic             func;
    logic             err;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_d;
  } meta_t;

  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [DIV_STEPS-1:0] n;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    meta_t     meta;
    div_lane_t th;
    div_lane_t ph;
  } div_stage_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cor_lane_t;

  typedef struct packed {
    logic      valid;
    meta_t     meta;
    cor_lane_t th;
    cor_lane_t ph;
  } cor_stage_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Q1.30 product, rounded half up
  function automatic logic signed [UW-1:0] mul_q30(input logic signed [UW-1:0] a,
                                                   input logic signed [UW-1:0] b);
    logic signed [2*UW-1:0] p;
    p = a * b + 64'sd536870912;
    return p[61:30];
  endfunction

  // Q1.30 times Q8.8 radius, rounded half up, saturated
  function automatic logic signed [COORD_W-1:0] scale_out(input logic signed [UW-1:0] u,
                                                          input logic [RAD_W-1:0] rad);
    logic signed [UW+RAD_W:0] p;
    logic signed [UW+RAD_W-30:0] t;
    logic signed [COORD_W-1:0] v;
    p = u * $signed({1'b0, rad}) + 49'sd536870912;
    t = p[UW+RAD_W:30];
    if (t > 19'sd65535)       v = 17'sd65535;
    else if (t < -19'sd65535) v = -17'sd65535;
    else                      v = t[COORD_W-1:0];
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/uv_sphere_mesh_generator.sv
// uv_sphere_mesh_generator: top level, request decode, divider and CORDIC chains,
// scaling stages and result sequencer. Depends on uvs_pkg, uvs_div_cell, uvs_cordic_cell.
//
// Usage: a request word (in_func, in_ring_index, in_sector_index) is taken at a clock edge
// with in_valid high and in_stall low. A vertex request gives one result word with
// coordinates; a quad request gives six index words, out_last on the sixth; a request
// outside the mesh gives a single word with out_error set. A result word is taken at an
// edge with out_valid high and out_stall low.
// Pipeline: 33 divider cells, the CORDIC cells, two multiply stages, the output register.
// Throughput: one vertex word per cycle while out_stall is low; a quad holds the chain
// for its six-word burst, the output sequencer being the limit. The whole chain advances
// together, so a stalled output word holds every stage and in_stall rises; a word waiting
// at the output does not keep the chain from filling when the output slot frees in the
// same cycle. Reset clears all valid flags and loads 16 rings, 16 sectors, radius 1.0.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none
module uv_sphere_mesh_generator #(
  parameter int MAX_RINGS    = uvs_pkg::MAX_RINGS_DEF,
  parameter int MAX_SECTORS  = uvs_pkg::MAX_SECTORS_DEF,
  parameter int ANGLE_STAGES = uvs_pkg::ANGLE_STAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [uvs_pkg::CFG_IW-1:0]         cfg_index,
  input  wire logic [uvs_pkg::RAD_W-1:0]          cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_func,
  input  wire logic [7:0]                         in_ring_index,
  input  wire logic [7:0]                         in_sector_index,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [uvs_pkg::COORD_W-1:0]      out_coord_x,
  output logic signed [uvs_pkg::COORD_W-1:0]      out_coord_y,
  output logic signed [uvs_pkg::COORD_W-1:0]      out_coord_z,
  output logic [uvs_pkg::IDX_W-1:0]               out_vertex_index,
  output logic                                    out_last,
  output logic                                    out_error
);

  localparam int CNT_W = uvs_pkg::CNT_W;
  localparam int DW    = uvs_pkg::DIV_W;
  localparam int IW    = uvs_pkg::IDX_W;
  localparam int CW    = uvs_pkg::CW;
  localparam int UW    = uvs_pkg::UW;
  localparam int XW    = uvs_pkg::COORD_W;

  logic [CNT_W-1:0] ring_count_r, sector_count_r;
  logic [uvs_pkg::RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r   <= CNT_W'(16);
      sector_count_r <= CNT_W'(16);
      radius_r       <= uvs_pkg::RAD_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::REG_RING_COUNT:    ring_count_r   <= cfg_wdata[CNT_W-1:0];
        uvs_pkg::REG_SECTOR_COUNT:  sector_count_r <= cfg_wdata[CNT_W-1:0];
        uvs_pkg::REG_SPHERE_RADIUS: radius_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] rings, secs;
  always_comb begin
    if (ring_count_r < CNT_W'(2))          rings = CNT_W'(2);
    else if (int'(ring_count_r) > MAX_RINGS) rings = CNT_W'(MAX_RINGS);
    else                                   rings = ring_count_r;
    if (sector_count_r < CNT_W'(2))          secs = CNT_W'(2);
    else if (int'(sector_count_r) > MAX_SECTORS) secs = CNT_W'(MAX_SECTORS);
    else                                     secs = sector_count_r;
  end

  logic [DW-1:0] div_th, div_ph;
  assign div_th = DW'({rings - CNT_W'(1), 1'b0});
  assign div_ph = DW'(secs - CNT_W'(1));

  logic adv;

  // request decode
  logic [CNT_W-1:0] r9, s9;
  logic req_err;
  logic [2*CNT_W-2:0] ring_base;
  uvs_pkg::div_stage_t div_chain [0:uvs_pkg::DIV_STEPS];

  assign r9 = CNT_W'(in_ring_index);
  assign s9 = CNT_W'(in_sector_index);
  assign ring_base = (2*CNT_W-1)'(in_ring_index) * (2*CNT_W-1)'(secs);

  always_comb begin
    if (in_func == uvs_pkg::FUNC_QUAD)
      req_err = (r9 + CNT_W'(1) >= rings) || (s9 + CNT_W'(1) >= secs);
    else
      req_err = (r9 >= rings) || (s9 >= secs);
    div_chain[0].valid      = in_valid;
    div_chain[0].meta.func  = in_func;
    div_chain[0].meta.err   = req_err;
    div_chain[0].meta.idx_a = IW'(ring_base + (2*CNT_W-1)'(in_sector_index));
    div_chain[0].meta.idx_d = div_chain[0].meta.idx_a + IW'(secs);
    div_chain[0].th.rem = DW'(in_ring_index >> 1);
    div_chain[0].th.n   = {in_ring_index[0], 32'(rings - CNT_W'(1))};
    div_chain[0].ph.rem = DW'(in_sector_index >> 1);
    div_chain[0].ph.n   = {in_sector_index[0], 32'((secs - CNT_W'(1)) >> 1)};
  end

  for (genvar g = 0; g < uvs_pkg::DIV_STEPS; g++) begin : g_div
    uvs_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .div_th  (div_th),
      .div_ph  (div_ph),
      .stage_i (div_chain[g]),
      .stage_o (div_chain[g+1])
    );
  end

  function automatic uvs_pkg::cor_lane_t cor_init(input logic [31:0] a);
    uvs_pkg::cor_lane_t l;
    logic [31:0] b;
    l.flip = a[31] ^ a[30];
    b = {a[31] ^ l.flip, a[30:0]};
    l.x = uvs_pkg::CORDIC_SEED;
    l.y = '0;
    l.z = CW'($signed(b));
    return l;
  endfunction

  uvs_pkg::cor_stage_t cor_chain [0:ANGLE_STAGES];

  always_comb begin
    cor_chain[0].valid = div_chain[uvs_pkg::DIV_STEPS].valid;
    cor_chain[0].meta  = div_chain[uvs_pkg::DIV_STEPS].meta;
    cor_chain[0].th    = cor_init(div_chain[uvs_pkg::DIV_STEPS].th.n[31:0]);
    cor_chain[0].ph    = cor_init(div_chain[uvs_pkg::DIV_STEPS].ph.n[31:0]);
  end

  for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cor
    uvs_cordic_cell #(.STAGE(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage_i (cor_chain[g]),
      .stage_o (cor_chain[g+1])
    );
  end

  // unit-sphere products
  logic signed [CW-1:0] ct, st, cp, sp;
  uvs_pkg::cor_stage_t cor_last;
  assign cor_last = cor_chain[ANGLE_STAGES];
  assign ct = cor_last.th.flip ? -cor_last.th.x : cor_last.th.x;
  assign st = cor_last.th.flip ? -cor_last.th.y : cor_last.th.y;
  assign cp = cor_last.ph.flip ? -cor_last.ph.x : cor_last.ph.x;
  assign sp = cor_last.ph.flip ? -cor_last.ph.y : cor_last.ph.y;

  logic m1_valid_r, m2_valid_r;
  uvs_pkg::meta_t m1_meta_r, m2_meta_r;
  logic signed [UW-1:0] ux_r, uy_r, uz_r;
  logic signed [XW-1:0] cx_r, cy_r, cz_r;
  logic signed [CW-1:0] nct;
  assign nct = -ct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r <= cor_last.valid;
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_meta_r <= cor_last.meta;
      ux_r <= uvs_pkg::mul_q30(cp[UW-1:0], st[UW-1:0]);
      uy_r <= nct[UW-1:0];
      uz_r <= uvs_pkg::mul_q30(sp[UW-1:0], st[UW-1:0]);
      m2_meta_r <= m1_meta_r;
      cx_r <= uvs_pkg::scale_out(ux_r, radius_r);
      cy_r <= uvs_pkg::scale_out(uy_r, radius_r);
      cz_r <= uvs_pkg::scale_out(uz_r, radius_r);
    end
  end

  // result sequencer
  logic out_valid_r, out_last_r, out_error_r;
  logic signed [XW-1:0] ox_r, oy_r, oz_r;
  logic [IW-1:0] idx_r, oa_r, od_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_nxt;

  assign adv = !out_valid_r || (!out_stall && out_last_r);
  assign in_stall = !adv;

  always_comb begin
    cnt_nxt = cnt_r + 3'd1;
    case (cnt_nxt)
      3'd1:    idx_nxt = oa_r + IW'(1);
      3'd2:    idx_nxt = od_r + IW'(1);
      3'd3:    idx_nxt = od_r + IW'(1);
      3'd4:    idx_nxt = od_r;
      default: idx_nxt = oa_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oa_r  <= m2_meta_r.idx_a;
      od_r  <= m2_meta_r.idx_d;
      cnt_r <= 3'd0;
      out_error_r <= m2_meta_r.err;
      if (m2_meta_r.err) begin
        ox_r <= '0; oy_r <= '0; oz_r <= '0;
        idx_r <= '0;
        out_last_r <= 1'b1;
      end else if (m2_meta_r.func == uvs_pkg::FUNC_QUAD) begin
        ox_r <= '0; oy_r <= '0; oz_r <= '0;
        idx_r <= m2_meta_r.idx_a;
        out_last_r <= 1'b0;
      end else begin
        ox_r <= cx_r; oy_r <= cy_r; oz_r <= cz_r;
        idx_r <= m2_meta_r.idx_a;
        out_last_r <= 1'b1;
      end
    end else if (!out_stall && !out_last_r) begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      out_last_r <= (cnt_nxt == 3'd5);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coord_x      = ox_r;
  assign out_coord_y      = oy_r;
  assign out_coord_z      = oz_r;
  assign out_vertex_index = idx_r;
  assign out_last         = out_last_r;
  assign out_error        = out_error_r;

endmodule
`default_nettype wire

// File: rtl/core/uvs_div_cell.sv
// uvs_div_cell: one restoring-division step for the polar and azimuth angle lanes.
// Depends on uvs_pkg.
`default_nettype none
module uvs_div_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic [uvs_pkg::DIV_W-1:0]  div_th,
  input  wire logic [uvs_pkg::DIV_W-1:0]  div_ph,
  input  wire uvs_pkg::div_stage_t        stage_i,
  output uvs_pkg::div_stage_t             stage_o
);

  uvs_pkg::div_stage_t stage_r, stage_nxt;

  function automatic uvs_pkg::div_lane_t step(input uvs_pkg::div_lane_t l,
                                              input logic [uvs_pkg::DIV_W-1:0] d);
    uvs_pkg::div_lane_t o;
    logic [uvs_pkg::DIV_W-1:0] t;
    logic ge;
    t = {l.rem[uvs_pkg::DIV_W-2:0], l.n[uvs_pkg::DIV_STEPS-1]};
    ge = (t >= d);
    o.rem = ge ? t - d : t;
    o.n = {l.n[uvs_pkg::DIV_STEPS-2:0], ge};
    return o;
  endfunction

  always_comb begin
    stage_nxt = stage_i;
    stage_nxt.th = step(stage_i.th, div_th);
    stage_nxt.ph = step(stage_i.ph, div_ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

// File: rtl/core/uvs_cordic_cell.sv
// uvs_cordic_cell: one rotation-mode CORDIC step for both angle lanes.
// Depends on uvs_pkg.
`default_nettype none
module uvs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire uvs_pkg::cor_stage_t  stage_i,
  output uvs_pkg::cor_stage_t       stage_o
);

  localparam logic signed [uvs_pkg::CW-1:0] ATAN =
    $signed({2'b00, uvs_pkg::atan_turn(STAGE)});

  uvs_pkg::cor_stage_t stage_r, stage_nxt;

  function automatic uvs_pkg::cor_lane_t rot(input uvs_pkg::cor_lane_t l);
    uvs_pkg::cor_lane_t o;
    logic signed [uvs_pkg::CW-1:0] dx;
    logic signed [uvs_pkg::CW-1:0] dy;
    dx = l.y >>> STAGE;
    dy = l.x >>> STAGE;
    o.flip = l.flip;
    if (!l.z[uvs_pkg::CW-1]) begin
      o.x = l.x - dx;
      o.y = l.y + dy;
      o.z = l.z - ATAN;
    end else begin
      o.x = l.x + dx;
      o.y = l.y - dy;
      o.z = l.z + ATAN;
    end
    return o;
  endfunction

  always_comb begin
    stage_nxt = stage_i;
    stage_nxt.th = rot(stage_i.th);
    stage_nxt.ph = rot(stage_i.ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

// File: dv/uv_sphere_mesh_generator_tb.sv
// uv_sphere_mesh_generator_tb: self-checking bench for the UV-sphere mesh generator.
// Drives vertex and quad request words, predicts each result word from fixed-point
// CORDIC math of its own, and depends only on uvs_pkg and the generator RTL.
`timescale 1ns / 100ps
`default_nettype none
module uv_sphere_mesh_generator_tb;

  localparam int LAT         = uvs_pkg::ANGLE_STAGES_DEF + 36;
  localparam int XW          = uvs_pkg::COORD_W;
  localparam int IW          = uvs_pkg::IDX_W;
  localparam int HOLD_AT     = 320;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic signed [XW-1:0] x, y, z;
    logic [IW-1:0] vidx;
    logic lst, err;
  } vtx_word_t;

  typedef struct {
    logic f;
    logic [7:0] r, s;
    bit has_exp;
    vtx_word_t ex;
  } req_row_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [uvs_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [uvs_pkg::RAD_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_func = 0;
  logic [7:0] in_ring_index = 0, in_sector_index = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, out_last, out_error;
  logic signed [XW-1:0] out_coord_x, out_coord_y, out_coord_z;
  logic [IW-1:0] out_vertex_index;

  uv_sphere_mesh_generator dut (.*);

  always #5 clk = ~clk;

  logic [8:0] rings_q = 16, secs_q = 16;
  logic [15:0] radius_q = 256;
  vtx_word_t pending_q[$];
  int mism = 0, nwords = 0, nreq = 0;
  bit quiet = 0;      // no idling stretch
  int hold_cnt = 0;   // long receiver hold-off
  bit hold_done = 0;

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic void cordic_sc(logic [31:0] a, output longint c, output longint s);
    logic [31:0] atab[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
      32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
      32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
      32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    bit flip;
    longint x, y, z, dx, dy;
    flip = (a[31:30] == 2'd1 || a[31:30] == 2'd2);
    if (flip) a = a + 32'h80000000;
    x = 652032874; y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < uvs_pkg::ANGLE_STAGES_DEF && i < 24; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return fshift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [XW-1:0] to_coord(longint u);
    longint v;
    v = fshift(u * longint'(radius_q) + (64'sd1 <<< 29), 30);
    if (v > uvs_pkg::COORD_LIMIT) v = uvs_pkg::COORD_LIMIT;
    if (v < -uvs_pkg::COORD_LIMIT) v = -uvs_pkg::COORD_LIMIT;
    return v[XW-1:0];
  endfunction

  function automatic int eff_count(logic [8:0] v);
    return (v < 2) ? 2 : (v > 256) ? 256 : int'(v);
  endfunction

  function automatic void predict_mesh_words(logic f, logic [7:0] r, logic [7:0] s);
    int nr, ns;
    vtx_word_t w;
    longint ct, st, cp, sp;
    logic [63:0] dr, ds;
    logic [31:0] ath, aph;
    logic [IW-1:0] a, b, c, d;
    nr = eff_count(rings_q); ns = eff_count(secs_q);
    w = '{0, 0, 0, 0, 1, 1};
    if (f == uvs_pkg::FUNC_VERTEX) begin
      if (r >= nr || s >= ns) begin
        pending_q.push_back(w); return;
      end
      dr = 64'(2 * (nr - 1)); ds = 64'(ns - 1);
      ath = 32'(((64'(r) << 32) + dr / 2) / dr);
      aph = 32'(((64'(s) << 32) + ds / 2) / ds);
      cordic_sc(ath, ct, st);
      cordic_sc(aph, cp, sp);
      w.x = to_coord(q30_mul(cp, st));
      w.y = to_coord(-ct);
      w.z = to_coord(q30_mul(sp, st));
      w.vidx = IW'(r * ns + s); w.err = 1'b0;
      pending_q.push_back(w);
    end else begin
      if (r + 1 >= nr || s + 1 >= ns) begin
        pending_q.push_back(w); return;
      end
      a = IW'(r * ns + s); b = IW'(r * ns + s + 1);
      c = IW'((r + 1) * ns + s + 1); d = IW'((r + 1) * ns + s);
      w.err = 1'b0; w.lst = 1'b0;
      w.vidx = a; pending_q.push_back(w);
      w.vidx = b; pending_q.push_back(w);
      w.vidx = c; pending_q.push_back(w);
      pending_q.push_back(w);
      w.vidx = d; pending_q.push_back(w);
      w.vidx = a; w.lst = 1'b1; pending_q.push_back(w);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    vtx_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      nwords++;
      if (pending_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result word idx=%0d", out_vertex_index);
      end else begin
        e = pending_q.pop_front();
        if (out_coord_x !== e.x || out_coord_y !== e.y || out_coord_z !== e.z ||
            out_vertex_index !== e.vidx || out_last !== e.lst || out_error !== e.err) begin
          mism++;
          if (mism <= 10) begin
            $display("mismatch: exp x=%0d y=%0d z=%0d i=%0d l=%0b e=%0b",
                     e.x, e.y, e.z, e.vidx, e.lst, e.err);
            $display("          got x=%0d y=%0d z=%0d i=%0d l=%0b e=%0b",
                     out_coord_x, out_coord_y, out_coord_z, out_vertex_index,
                     out_last, out_error);
          end
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1; hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && nreq >= HOLD_AT) begin
      out_stall <= 1'b1; hold_cnt <= HOLD_CYCLES; hold_done <= 1'b1;
    end else
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);
  end

  // predicted at accept edge so config at that time applies
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      nreq++;
      predict_mesh_words(in_func, in_ring_index, in_sector_index);
    end
  end

  task automatic send_word(logic f, logic [7:0] r, logic [7:0] s);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_func <= f; in_ring_index <= r; in_sector_index <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LAT + 8) @(negedge clk);
  endtask

  task automatic write_reg(logic [uvs_pkg::CFG_IW-1:0] i, logic [uvs_pkg::RAD_W-1:0] v);
    drain_wait();
    cfg_we <= 1; cfg_index <= i; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    if (i == uvs_pkg::REG_RING_COUNT) rings_q = v[8:0];
    else if (i == uvs_pkg::REG_SECTOR_COUNT) secs_q = v[8:0];
    else if (i == uvs_pkg::REG_SPHERE_RADIUS) radius_q = v;
  endtask

  task automatic rand_phase(int n);
    logic [7:0] r, s;
    int nr, ns;
    nr = eff_count(rings_q); ns = eff_count(secs_q);
    repeat (n) begin
      r = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(nr - 1));
      s = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ns - 1));
      send_word(1'($urandom), r, s);
    end
  endtask

  req_row_t rows[$];

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    vtx_word_t e;
    e = '{0, 0, 0, 0, 0, 0};
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: poles, near-equator, extremes, errors, quads
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 0, 0, 1, '{0, -256, 0, 0, 1, 0}});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 15, 0, 0, e});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 0, 15, 0, e});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 7, 5, 0, e});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 15, 15, 0, e});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 16, 0, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 0, 16, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_VERTEX, 255, 255, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 0, 0, 0, e});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 14, 14, 0, e});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 15, 0, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 0, 15, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 255, 255, 1, '{0, 0, 0, 0, 1, 1}});
    rows.push_back('{uvs_pkg::FUNC_QUAD, 8'h55, 8'hAA, 1, '{0, 0, 0, 0, 1, 1}});
    foreach (rows[i]) begin
      send_word(rows[i].f, rows[i].r, rows[i].s);
      if (rows[i].has_exp) begin
        void'(pending_q.pop_back());
        pending_q.push_back(rows[i].ex);
      end
    end
    // extreme settings
    write_reg(uvs_pkg::REG_RING_COUNT, 16'd256);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'd256);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'hFFFF);
    send_word(uvs_pkg::FUNC_VERTEX, 255, 255);
    send_word(uvs_pkg::FUNC_VERTEX, 128, 64);
    send_word(uvs_pkg::FUNC_QUAD, 254, 254);
    send_word(uvs_pkg::FUNC_QUAD, 255, 0);
    rand_phase(90);
    write_reg(uvs_pkg::REG_RING_COUNT, 16'd0);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'd511);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'd0);
    rand_phase(60);
    write_reg(uvs_pkg::REG_RING_COUNT, 16'd300);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'd1);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'h1234);
    rand_phase(60);
    write_reg(uvs_pkg::REG_RING_COUNT, 16'd3);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'd40);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'h8000);
    quiet = 1;
    rand_phase(80);
    quiet = 0;
    // receiver hold-off starts on its own once enough requests went in
    rand_phase(60);
    drain_wait();
    write_reg(uvs_pkg::REG_RING_COUNT, 16'h01FF);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'h00AA);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'h00FF);
    rand_phase(60);
    write_reg(uvs_pkg::REG_RING_COUNT, 16'h0155);
    write_reg(uvs_pkg::REG_SECTOR_COUNT, 16'h0100);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 16'hFF00);
    rand_phase(60);
    drain_wait();
    $display("Covered %0d requests and %0d result words over several mesh and radius settings.",
             nreq, nwords);
    if (mism == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", mism, pending_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: uv_sphere_mesh_generator.f
rtl/core/uvs_pkg.sv
rtl/core/uvs_div_cell.sv
rtl/core/uvs_cordic_cell.sv
rtl/core/uv_sphere_mesh_generator.sv
dv/uv_sphere_mesh_generator_tb.sv
